// File: sv/signed_decimal_formatter_macros.svh
// ----------------------------------------------------------------------------
// Signed decimal formatter assertion macros
// Shared checking macros for the formatter's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SDF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("signed_decimal_formatter: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("signed_decimal_formatter: next-cycle check failed");

`endif

// File: sv/sdf_pkg.sv
// ----------------------------------------------------------------------------
// Signed decimal formatter package
// Character codes and the BCD digit correction used by the formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // Shift-and-add-three correction: a digit of five or more gets three added
    // so that the following left shift carries correctly into the next digit.
    function automatic digit_t dabble_adjust(input digit_t d);
        digit_t r;
        if (d >= 4'd5) begin
            r = d + 4'd3;
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

// File: sv/signed_decimal_formatter.sv
// ----------------------------------------------------------------------------
// Signed decimal formatter
// Prints one two's-complement value as a run of ASCII characters.
// ----------------------------------------------------------------------------
// A request carries one DATA_WIDTH-bit two's-complement value. The block
// answers with a run of ASCII characters: '-' for a negative value, then the
// decimal magnitude, most significant digit first, without leading zeros
// (zero prints as "0"). The last character of the run has m_is_last set.
// The magnitude is converted one bit per cycle by a shift-and-add-three BCD
// register. Leading zero digits are then dropped one per cycle, after which
// the block moves on from the first digit that stays to the sign or the
// digits, and one character leaves per cycle while the output side takes
// them. NDIG, the digit capacity, is 10 at the default width of 32 bits.
// s_ready is high only between values.
// ----------------------------------------------------------------------------
module signed_decimal_formatter
    import sdf_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_signed_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [CHAR_W-1:0]            m_out_char,
    output logic                         m_is_last
);

    `include "signed_decimal_formatter_macros.svh"

    // Decimal digits needed for any DATA_WIDTH-bit unsigned magnitude.
    localparam int NDIG      = ((DATA_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W     = NDIG * DIGIT_W;
    localparam int BIT_CNT_W = $clog2(DATA_WIDTH + 1);
    localparam int DIG_CNT_W = $clog2(NDIG + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [DATA_WIDTH-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    char_t                  m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic                   accept;
    logic                   out_free;
    logic [DATA_WIDTH-1:0]  in_raw;
    logic [BCD_W-1:0]       bcd_adj;
    digit_t                 top_digit;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign in_raw     = s_signed_value;
    assign top_digit  = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_is_last  = m_last_reg;

    // Digit corrections ahead of each conversion shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = dabble_adjust(bcd_reg[i*DIGIT_W +: DIGIT_W]);
        end
    end

    // Next-state and datapath control.
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next     = in_raw[DATA_WIDTH-1];
                    mag_next     = in_raw[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - in_raw)
                                                        : in_raw;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(DATA_WIDTH);
                    dig_cnt_next = DIG_CNT_W'(NDIG);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                // One magnitude bit enters the BCD register per cycle.
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[DATA_WIDTH-1]};
                mag_next     = {mag_reg[DATA_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(1)) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, but keep at least one digit.
                if ((top_digit == '0) && (dig_cnt_reg != DIG_CNT_W'(1))) begin
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else if (neg_reg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    m_last_next  = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mag_reg     <= mag_next;
            bcd_reg     <= bcd_next;
            neg_reg     <= neg_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            m_char_reg  <= m_char_next;
            m_last_reg  <= m_last_next;
        end
    end

    // A digit about to be printed is a valid decimal digit.
    `SDF_ASSERT_SAME(a_digit_range, aclk, aresetn, (state_reg == ST_EMIT), (top_digit <= 4'd9))

    // The digit count never runs out while digits remain to be handled.
    `SDF_ASSERT_SAME(a_dig_cnt_live, aclk, aresetn,
        ((state_reg == ST_SKIP) || (state_reg == ST_EMIT)), (dig_cnt_reg != '0))

    // The final digit closes the run and frees the input side.
    `SDF_ASSERT_NEXT(a_last_closes, aclk, aresetn,
        ((state_reg == ST_EMIT) && out_free && (dig_cnt_reg == DIG_CNT_W'(1))),
        ((state_reg == ST_IDLE) && m_valid_reg && m_last_reg))

    // A minus sign is never the last character of a run.
    `SDF_ASSERT_SAME(a_minus_not_last, aclk, aresetn,
        (m_valid_reg && (m_char_reg == CHAR_MINUS)), !m_last_reg)

endmodule

// File: verif/decimal_run_checker.sv
// ----------------------------------------------------------------------------
// Decimal run checker
// Watches both channels of the signed decimal formatter. Every accepted
// request is turned into its expected character run, and every accepted
// character is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
module decimal_run_checker
    import sdf_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_signed_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CHAR_W-1:0]     m_out_char,
    input  logic                  m_is_last,
    output int                    fail_count,
    output int                    pending_chars
);

    localparam int RADIX = 10;

    typedef struct packed {
        char_t ch;
        logic  last;
    } run_char_t;

    run_char_t char_queue[$];
    int        mismatches = 0;

    // Append the run for one value: an optional minus sign, then the digits
    // of the magnitude, most significant first, with the final one flagged.
    // The most negative value negates to itself, which read unsigned is the
    // correct magnitude.
    function automatic void push_decimal_chars(input logic [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] mag;
        digit_t                digits[$];
        run_char_t             ent;
        mag = value[DATA_WIDTH-1] ? -value : value;
        if (value[DATA_WIDTH-1]) begin
            ent.ch   = CHAR_MINUS;
            ent.last = 1'b0;
            char_queue.push_back(ent);
        end
        do begin
            digits.push_front(digit_t'(mag % RADIX));
            mag = mag / RADIX;
        end while (mag != 0);
        foreach (digits[i]) begin
            ent.ch   = CHAR_ZERO + char_t'(digits[i]);
            ent.last = (i == digits.size() - 1);
            char_queue.push_back(ent);
        end
    endfunction

    // Predict on each accepted request, compare on each accepted character.
    always @(posedge aclk) begin : watch
        run_char_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                push_decimal_chars(s_signed_value);
            end
            if (m_valid && m_ready) begin
                if (char_queue.size() == 0) begin
                    $error("unexpected character %h with no request waiting", m_out_char);
                    mismatches++;
                end else begin
                    want = char_queue.pop_front();
                    if (m_out_char !== want.ch) begin
                        $error("out_char: expected %h, actual %h", want.ch, m_out_char);
                        mismatches++;
                    end
                    if (m_is_last !== want.last) begin
                        $error("is_last: expected %b, actual %b", want.last, m_is_last);
                        mismatches++;
                    end
                end
            end
        end
        pending_chars <= char_queue.size();
        fail_count    <= mismatches;
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Signed decimal formatter testbench
// Sends directed and random 32-bit values through the formatter with random
// gaps on the request side and random stalls on the character side, and
// lets the run checker compare every character that comes out.
// ----------------------------------------------------------------------------
module testbench;
    import sdf_pkg::*;

    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 470;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_WAIT     = 5;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [DATA_WIDTH-1:0] s_signed_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [CHAR_W-1:0]            m_out_char;
    logic                         m_is_last;

    int fail_count;
    int pending_chars;
    int cycle_count = 0;
    bit no_idle;

    logic [DATA_WIDTH-1:0] directed_values[] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF7, 32'hFFFF_FFF6,
        32'd99, 32'd100, 32'd999_999_999, 32'd1_000_000_000, 32'hC465_3600,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd1_234_567_890, 32'hB669_FD2E, 32'd1_999_999_999, 32'd2_000_000_000
    };

    signed_decimal_formatter #(
        .DATA_WIDTH(DATA_WIDTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_signed_value(s_signed_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_is_last     (m_is_last)
    );

    decimal_run_checker #(
        .DATA_WIDTH(DATA_WIDTH)
    ) run_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_signed_value(s_signed_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_is_last     (m_is_last),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    // Clock generation.
    always #5 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Hand one value to the block after a random gap, and hold it until taken.
    task automatic send_value(input logic [DATA_WIDTH-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_signed_value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Random value with a mix of digit counts, decade edges and extremes.
    function automatic logic [DATA_WIDTH-1:0] pick_value();
        logic [DATA_WIDTH-1:0] mag;
        logic [DATA_WIDTH-1:0] pow;
        int                    ndig;
        int                    kind;
        kind = $urandom_range(0, 9);
        pow  = 1;
        case (kind)
            0, 1, 2, 9: begin
                return $urandom;
            end
            3, 4, 5: begin
                ndig = $urandom_range(1, 10);
                if (ndig == 10) begin
                    mag = $urandom_range(1_000_000_000, 32'h7FFF_FFFF);
                end else begin
                    repeat (ndig) pow = pow * 10;
                    mag = $urandom_range(0, pow - 1);
                end
            end
            6: begin
                repeat ($urandom_range(0, 9)) pow = pow * 10;
                mag = pow - $urandom_range(0, 1);
            end
            7: begin
                mag = $urandom_range(0, 20);
            end
            default: begin
                mag = $urandom_range(0, 3);
                return $urandom_range(0, 1) ? 32'h8000_0000 + mag : 32'h7FFF_FFFF - mag;
            end
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Character side: a random stall before each character.
    initial begin : char_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Reset, directed values, random values, then drain and give the verdict.
    initial begin : stimulus
        no_idle        = 1'b0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_signed_value <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Every fourth stretch of items runs back to back on both sides.
            no_idle = ((i / 60) % 4 == 3);
            send_value(pick_value());
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_chars != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/sdf_pkg.sv
sv/signed_decimal_formatter.sv
verif/decimal_run_checker.sv
verif/testbench.sv
